/* hdl/tex_addr_pkg.sv */
// Shared types, constants and helpers for the texture address unit.
// Used by texture_address_wrap_top; no dependencies.
package tex_addr_pkg;

   localparam int DEST_W      = 13;              // destination coordinate
   localparam int TEXEL_W     = 13;              // texel coordinate on output
   localparam int CSR_DATA_W  = 14;              // widest register
   localparam int CSR_IDX_W   = 3;
   localparam int MODE_W      = 3;
   localparam int SIZE_W      = 14;              // size register width
   localparam int OFFSET_W    = 16;              // signed dest - origin
   localparam int MAG_W       = 14;              // |n| or -n-1
   localparam int DIV_W       = SIZE_W + 1;      // divisor up to 2*size
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES  = (MAG_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
   localparam int NUM_AXES    = 2;
   localparam int SIZE_REG_MAX = (2 ** SIZE_W) - 1;
   localparam int MAX_SIZE_DEFAULT = 8192;

   typedef enum logic [MODE_W-1:0] {
      MODE_REPEAT      = 3'd0,
      MODE_CLAMP       = 3'd1,
      MODE_MIRROR      = 3'd2,
      MODE_MIRROR_ONCE = 3'd3,
      MODE_BORDER      = 3'd4
   } addr_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X      = 3'd0,
      CSR_ORIGIN_Y      = 3'd1,
      CSR_SOURCE_WIDTH  = 3'd2,
      CSR_SOURCE_HEIGHT = 3'd3,
      CSR_MODE_U        = 3'd4,
      CSR_MODE_V        = 3'd5
   } csr_index_type;

   // Per-axis payload in the remainder pipeline.
   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
      logic [DIV_W-1:0] rem;
   } axis_div_type;

   // Per-axis payload after the wrap step.
   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
      logic [DIV_W-1:0] wrap;
   } axis_fin_type;

   // One restoring remainder step; rem < d on entry and on exit.
   function automatic logic [DIV_W-1:0] div_step(input logic [DIV_W-1:0] rem,
                                                 input logic             bit_in,
                                                 input logic [DIV_W-1:0] d);
      logic [DIV_W:0] t;
      t = {rem, bit_in};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
      end
      return t[DIV_W-1:0];
   endfunction

endpackage

/* hdl/texture_address_wrap_top.sv */
// Texture address unit: destination pixel to source texel with per-axis
// address modes (repeat, clamp, mirror, mirror once, border).
// Depends on tex_addr_pkg.
//
// Pipeline: an accepted req beat passes the entry stage, 7 remainder stages
//   at 2 quotient bits each, the wrap stage and the output register.
// Throughput: one beat per cycle while rsp_stall is low; the remainder unit is fully pipelined.
// Stall: a bubble collapses as the pipe fills; req_stall only rises when
//   every stage holds a beat and rsp_stall holds the output.
// Reset: synchronous, clears all valid bits and loads register defaults
//   (origins 0, sizes 1, both modes repeat).
module texture_address_wrap_top #(
   parameter int MAX_SIZE = tex_addr_pkg::MAX_SIZE_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_wr_en,
   input  logic [tex_addr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tex_addr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [tex_addr_pkg::DEST_W-1:0]       req_dest_x,
   input  logic [tex_addr_pkg::DEST_W-1:0]       req_dest_y,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tex_addr_pkg::TEXEL_W-1:0]      rsp_texel_x,
   output logic [tex_addr_pkg::TEXEL_W-1:0]      rsp_texel_y,
   output logic                                  rsp_skip
);

   localparam int SIZE_W     = tex_addr_pkg::SIZE_W;
   localparam int DIV_W      = tex_addr_pkg::DIV_W;
   localparam int MAG_W      = tex_addr_pkg::MAG_W;
   localparam int OFFSET_W   = tex_addr_pkg::OFFSET_W;
   localparam int DEST_W     = tex_addr_pkg::DEST_W;
   localparam int TEXEL_W    = tex_addr_pkg::TEXEL_W;
   localparam int NST        = tex_addr_pkg::DIV_STAGES;
   localparam int BPS        = tex_addr_pkg::BITS_PER_STAGE;
   localparam int NAX        = tex_addr_pkg::NUM_AXES;
   // Effective sizes saturate here; a cap above the register range never bites.
   localparam int SIZE_CAP_INT = (MAX_SIZE > tex_addr_pkg::SIZE_REG_MAX) ?
                                 tex_addr_pkg::SIZE_REG_MAX : MAX_SIZE;
   localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_CAP_INT[SIZE_W-1:0];
   localparam logic [SIZE_W-1:0] SIZE_ONE = SIZE_W'(1);
   localparam logic [DIV_W-1:0]  DIV_ONE  = DIV_W'(1);

   // ------------------------------------------------------------------
   // Configuration registers (axis 0 = x/u, axis 1 = y/v)
   // ------------------------------------------------------------------
   logic [SIZE_W-1:0]                origin_ff [NAX];
   logic [SIZE_W-1:0]                size_ff   [NAX];
   logic [tex_addr_pkg::MODE_W-1:0]  mode_ff   [NAX];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NAX; a++) begin
            origin_ff[a] <= '0;
            size_ff[a]   <= SIZE_ONE;
            mode_ff[a]   <= tex_addr_pkg::MODE_REPEAT;
         end
      end else if (csr_wr_en) begin
         case (tex_addr_pkg::csr_index_type'(csr_index))
            tex_addr_pkg::CSR_ORIGIN_X:      origin_ff[0] <= csr_wdata;
            tex_addr_pkg::CSR_ORIGIN_Y:      origin_ff[1] <= csr_wdata;
            tex_addr_pkg::CSR_SOURCE_WIDTH:  size_ff[0]   <= csr_wdata;
            tex_addr_pkg::CSR_SOURCE_HEIGHT: size_ff[1]   <= csr_wdata;
            tex_addr_pkg::CSR_MODE_U:
               mode_ff[0] <= csr_wdata[tex_addr_pkg::MODE_W-1:0];
            tex_addr_pkg::CSR_MODE_V:
               mode_ff[1] <= csr_wdata[tex_addr_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective size in [1, cap] and the modulus: 2s for mirror, s otherwise.
   // The user must change registers only while the pipe is empty (not enforced here), so every stage reads them.
   logic [SIZE_W-1:0]           s_eff [NAX];
   logic [DIV_W-1:0]            dsel  [NAX];
   tex_addr_pkg::addr_mode_type mode  [NAX];

   always_comb begin
      for (int a = 0; a < NAX; a++) begin
         mode[a] = tex_addr_pkg::addr_mode_type'(mode_ff[a]);
         if (size_ff[a] == '0) begin
            s_eff[a] = SIZE_ONE;
         end else if (size_ff[a] > SIZE_CAP) begin
            s_eff[a] = SIZE_CAP;
         end else begin
            s_eff[a] = size_ff[a];
         end
         if (mode[a] == tex_addr_pkg::MODE_MIRROR) begin
            dsel[a] = {s_eff[a], 1'b0};
         end else begin
            dsel[a] = {1'b0, s_eff[a]};
         end
      end
   end

   // ------------------------------------------------------------------
   // Flow control: each stage loads when empty or when the next one moves
   // ------------------------------------------------------------------
   logic          ent_vld_ff;
   logic [NST-1:0] div_vld_ff;
   logic          fin_vld_ff;
   logic          out_vld_ff;

   logic           adv_out;
   logic           adv_fin;
   logic [NST-1:0] adv_div;
   logic           adv_ent;

   always_comb begin
      adv_out = !out_vld_ff || !rsp_stall;
      adv_fin = !fin_vld_ff || adv_out;
      adv_div[NST-1] = !div_vld_ff[NST-1] || adv_fin;
      for (int k = NST - 2; k >= 0; k--) begin
         adv_div[k] = !div_vld_ff[k] || adv_div[k+1];
      end
      adv_ent = !ent_vld_ff || adv_div[0];
   end

   assign req_stall = !adv_ent;

   // ------------------------------------------------------------------
   // Entry stage: signed offset n, sign, and magnitude (n or -n-1)
   // ------------------------------------------------------------------
   logic [DEST_W-1:0]          dest [NAX];
   tex_addr_pkg::axis_div_type ent_in [NAX];
   tex_addr_pkg::axis_div_type ent_ff [NAX];

   assign dest[0] = req_dest_x;
   assign dest[1] = req_dest_y;

   always_comb begin
      logic [OFFSET_W-1:0] n;
      for (int a = 0; a < NAX; a++) begin
         n = {{(OFFSET_W - DEST_W){1'b0}}, dest[a]}
           - {{(OFFSET_W - SIZE_W){origin_ff[a][SIZE_W-1]}}, origin_ff[a]};
         ent_in[a].neg = n[OFFSET_W-1];
         ent_in[a].mag = n[OFFSET_W-1] ? ~n[MAG_W-1:0] : n[MAG_W-1:0];
         ent_in[a].rem = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= 1'b0;
      end else if (adv_ent) begin
         ent_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_ent) begin
         ent_ff <= ent_in;
      end
   end

   // ------------------------------------------------------------------
   // Remainder pipeline: mag mod dsel, BPS quotient bits per stage
   // ------------------------------------------------------------------
   tex_addr_pkg::axis_div_type div_in [NST][NAX];
   tex_addr_pkg::axis_div_type div_ff [NST][NAX];

   for (genvar k = 0; k < NST; k++) begin : g_div
      tex_addr_pkg::axis_div_type src [NAX];
      logic                       src_vld;

      if (k == 0) begin : g_first
         assign src     = ent_ff;
         assign src_vld = ent_vld_ff;
      end else begin : g_next
         assign src     = div_ff[k-1];
         assign src_vld = div_vld_ff[k-1];
      end

      always_comb begin
         for (int a = 0; a < NAX; a++) begin
            div_in[k][a] = src[a];
            for (int j = 0; j < BPS; j++) begin
               if (MAG_W - 1 - k * BPS - j >= 0) begin
                  div_in[k][a].rem = tex_addr_pkg::div_step(div_in[k][a].rem,
                                        src[a].mag[MAG_W - 1 - k * BPS - j],
                                        dsel[a]);
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_vld_ff[k] <= 1'b0;
         end else if (adv_div[k]) begin
            div_vld_ff[k] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (adv_div[k]) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // Wrap stage: sign-independent modulo (repeat and mirror both use it)
   // ------------------------------------------------------------------
   tex_addr_pkg::axis_fin_type fin_in [NAX];
   tex_addr_pkg::axis_fin_type fin_ff [NAX];

   always_comb begin
      for (int a = 0; a < NAX; a++) begin
         fin_in[a].neg = div_ff[NST-1][a].neg;
         fin_in[a].mag = div_ff[NST-1][a].mag;
         // negative side counts down from the top of the period
         if (div_ff[NST-1][a].neg) begin
            fin_in[a].wrap = dsel[a] - DIV_ONE - div_ff[NST-1][a].rem;
         end else begin
            fin_in[a].wrap = div_ff[NST-1][a].rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
      end else if (adv_fin) begin
         fin_vld_ff <= div_vld_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv_fin) begin
         fin_ff <= fin_in;
      end
   end

   // ------------------------------------------------------------------
   // Mode select and output register
   // ------------------------------------------------------------------
   logic [SIZE_W-1:0] tex [NAX];
   logic [NAX-1:0]    ax_skip;
   logic              skip_in;
   logic [TEXEL_W-1:0] texel_x_in;
   logic [TEXEL_W-1:0] texel_y_in;

   always_comb begin
      logic [DIV_W-1:0] refl;
      for (int a = 0; a < NAX; a++) begin
         ax_skip[a] = 1'b0;
         refl       = dsel[a] - DIV_ONE - fin_ff[a].wrap;
         case (mode[a])
            tex_addr_pkg::MODE_CLAMP: begin
               if (fin_ff[a].neg) begin
                  tex[a] = '0;
               end else if (fin_ff[a].mag >= s_eff[a]) begin
                  tex[a] = s_eff[a] - SIZE_ONE;
               end else begin
                  tex[a] = fin_ff[a].mag;
               end
            end
            tex_addr_pkg::MODE_MIRROR: begin
               // upper half of the 2s period runs backwards
               if (fin_ff[a].wrap < {1'b0, s_eff[a]}) begin
                  tex[a] = fin_ff[a].wrap[SIZE_W-1:0];
               end else begin
                  tex[a] = refl[SIZE_W-1:0];
               end
            end
            tex_addr_pkg::MODE_MIRROR_ONCE: begin
               // mag already holds -n-1 for negative offsets
               ax_skip[a] = (fin_ff[a].mag >= s_eff[a]);
               tex[a]     = fin_ff[a].mag;
            end
            tex_addr_pkg::MODE_BORDER: begin
               ax_skip[a] = fin_ff[a].neg || (fin_ff[a].mag >= s_eff[a]);
               tex[a]     = fin_ff[a].mag;
            end
            default: begin
               // repeat, and the unused codes
               tex[a] = fin_ff[a].wrap[SIZE_W-1:0];
            end
         endcase
      end
      skip_in    = |ax_skip;
      texel_x_in = skip_in ? '0 : tex[0][TEXEL_W-1:0];
      texel_y_in = skip_in ? '0 : tex[1][TEXEL_W-1:0];
   end

   logic [TEXEL_W-1:0] texel_x_ff;
   logic [TEXEL_W-1:0] texel_y_ff;
   logic               skip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv_out) begin
         out_vld_ff <= fin_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out) begin
         texel_x_ff <= texel_x_in;
         texel_y_ff <= texel_y_in;
         skip_ff    <= skip_in;
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_texel_x = texel_x_ff;
   assign rsp_texel_y = texel_y_ff;
   assign rsp_skip    = skip_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_skip |-> (rsp_texel_x == '0) && (rsp_texel_y == '0))
      else $error("skipped beat carries a nonzero texel");

   a_empty_out_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with an empty output register");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_clamp_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (mode[0] == tex_addr_pkg::MODE_CLAMP)
      |-> ({1'b0, rsp_texel_x} < s_eff[0]))
      else $error("clamped column outside source width");

   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      fin_vld_ff |-> (fin_ff[1].wrap < dsel[1]))
      else $error("row remainder not below its modulus");

endmodule
